/* sv/mbcd_pkg.sv */
// Shared types, constants and helper functions of the mouse button chord detector.
package mbcd_pkg;

  localparam int NUM_BUTTONS  = 5;
  localparam int NUM_SUFFIXES = 7;
  localparam int BTN_W        = 3;
  localparam int SUF_W        = 3;
  localparam int CHORD_W      = NUM_BUTTONS * NUM_SUFFIXES;
  localparam int CHORD_IDX_W  = $clog2(CHORD_W);
  localparam int MODE_W       = 2 * NUM_BUTTONS;
  localparam int HOLD_W       = 12;
  localparam int HOLDS_W      = HOLD_W * NUM_BUTTONS;
  localparam int CFG_DATA_W   = HOLDS_W;
  localparam int POS_W        = 16;
  localparam int DRAG_W       = 8;
  localparam int QUEUE_DEPTH  = 2;

  localparam logic [BTN_W-1:0] MIDDLE_BUTTON     = BTN_W'(2);
  localparam logic [SUF_W-1:0] WHEEL_UP_SUFFIX   = SUF_W'(NUM_BUTTONS);
  localparam logic [SUF_W-1:0] WHEEL_DOWN_SUFFIX = SUF_W'(NUM_BUTTONS + 1);
  localparam logic [DRAG_W-1:0] DRAG_RESET       = DRAG_W'(8);

  localparam logic [1:0] MODE_CLICK   = 2'd0;
  localparam logic [1:0] MODE_DISABLE = 2'd1;

  typedef enum logic [2:0] {
    CMD_DOWN          = 3'd0,
    CMD_UP            = 3'd1,
    CMD_MOVE          = 3'd2,
    CMD_WHEEL         = 3'd3,
    CMD_TICK          = 3'd4,
    CMD_FLUSH_DELIVER = 3'd5,
    CMD_FLUSH_DROP    = 3'd6
  } cmd_e;

  typedef enum logic [2:0] {
    KIND_DECISION = 3'd0,
    KIND_CLICK    = 3'd1,
    KIND_DOWN     = 3'd2,
    KIND_UP       = 3'd3,
    KIND_CHORD    = 3'd4,
    KIND_SINGLE   = 3'd5
  } kind_e;

  typedef enum logic [2:0] {
    CFG_ENABLE = 3'd0,
    CFG_DRAG   = 3'd1,
    CFG_CHORD  = 3'd2,
    CFG_MODES  = 3'd3,
    CFG_HOLDS  = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    PH_IDLE     = 2'd0,
    PH_PENDING  = 2'd1,
    PH_CONSUMED = 2'd2,
    PH_PASS     = 2'd3
  } phase_e;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_DOWN,
    OP_UP,
    OP_MOVE,
    OP_WHEEL,
    OP_TICK,
    OP_FLUSH_DLV,
    OP_FLUSH_DROP
  } op_e;

  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_PRE,
    SEQ_WALK,
    SEQ_POST,
    SEQ_DEC
  } seq_e;

  typedef struct packed {
    op_e                     op;
    logic [BTN_W-1:0]        btn;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] wheel;
  } op_t;

  typedef struct packed {
    logic                enable;
    logic [DRAG_W-1:0]   drag;
    logic [CHORD_W-1:0]  chord_map;
    logic [MODE_W-1:0]   modes;
    logic [HOLDS_W-1:0]  holds;
  } cfg_t;

  typedef struct packed {
    kind_e             kind;
    logic [BTN_W-1:0]  which;
    logic [SUF_W-1:0]  suffix;
    logic [POS_W-1:0]  amount;
    logic              swallow;
    logic              last;
  } res_t;

  function automatic logic chord_mapped(logic [CHORD_W-1:0] map, logic [BTN_W-1:0] p,
                                        logic [SUF_W-1:0] s);
    int idx;
    idx = int'(p) * NUM_SUFFIXES + int'(s);
    if (p == MIDDLE_BUTTON || {1'b0, p} == {1'b0, s} || idx >= CHORD_W) begin
      return 1'b0;
    end
    return map[CHORD_IDX_W'(idx)];
  endfunction

  function automatic logic [1:0] single_mode(logic [MODE_W-1:0] modes, logic [BTN_W-1:0] b);
    return modes[int'(b) * 2 +: 2];
  endfunction

  function automatic logic is_armed(cfg_t cfg, logic [BTN_W-1:0] b);
    logic any;
    any = 1'b0;
    for (int s = 0; s < NUM_SUFFIXES; s++) begin
      any |= chord_mapped(cfg.chord_map, b, SUF_W'(s));
    end
    return (b != MIDDLE_BUTTON) && (single_mode(cfg.modes, b) != MODE_CLICK || any);
  endfunction

  function automatic res_t mk_res(kind_e kind, logic [BTN_W-1:0] which,
                                  logic [SUF_W-1:0] suffix, logic [POS_W-1:0] amount);
    res_t r;
    r.kind    = kind;
    r.which   = which;
    r.suffix  = suffix;
    r.amount  = amount;
    r.swallow = 1'b0;
    r.last    = 1'b0;
    return r;
  endfunction

endpackage

/* sv/mbcd_if.sv */
// Channel interfaces: mouse events in, results out, configuration writes.
interface mbcd_evt_if;
  logic               valid;
  logic               ready;
  logic [2:0]         cmd;
  logic [2:0]         button;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic signed [15:0] wheel_delta;
  modport source (output valid, cmd, button, pos_x, pos_y, wheel_delta, input ready);
  modport sink (input valid, cmd, button, pos_x, pos_y, wheel_delta, output ready);
endinterface

interface mbcd_res_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [2:0]  which_button;
  logic [2:0]  suffix;
  logic [15:0] amount;
  logic        swallow;
  logic        last;
  modport source (output valid, kind, which_button, suffix, amount, swallow, last,
                  input ready);
  modport sink (input valid, kind, which_button, suffix, amount, swallow, last,
                output ready);
endinterface

interface mbcd_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [59:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* sv/mbcd_front.sv */
// Front end: classifies incoming mouse events and queues them for the sequencer.
module mbcd_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  mbcd_evt_if.sink       evt_i,
  output mbcd_pkg::op_t  op_o,
  output logic           op_valid_o,
  input  logic           op_pop_i
);
  import mbcd_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  op_t              slot_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;
  op_t              dec;
  logic             push;
  logic             btn_ok;

  assign btn_ok = evt_i.button < BTN_W'(NUM_BUTTONS);

  always_comb begin
    dec.btn   = evt_i.button;
    dec.pos_x = evt_i.pos_x;
    dec.pos_y = evt_i.pos_y;
    dec.wheel = evt_i.wheel_delta;
    unique case (evt_i.cmd)
      CMD_DOWN:          dec.op = btn_ok ? OP_DOWN : OP_NOP;
      CMD_UP:            dec.op = btn_ok ? OP_UP : OP_NOP;
      CMD_MOVE:          dec.op = OP_MOVE;
      CMD_WHEEL:         dec.op = OP_WHEEL;
      CMD_TICK:          dec.op = OP_TICK;
      CMD_FLUSH_DELIVER: dec.op = OP_FLUSH_DLV;
      CMD_FLUSH_DROP:    dec.op = OP_FLUSH_DROP;
      default:           dec.op = OP_NOP;
    endcase
  end

  assign evt_i.ready = count_q != CNT_W'(QUEUE_DEPTH);
  assign push        = evt_i.valid && evt_i.ready;
  assign op_valid_o  = count_q != '0;
  assign op_o        = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (op_pop_i) rd_ptr_q <= rd_ptr_q + 1'b1;
      count_q <= count_q + CNT_W'(push) - CNT_W'(op_pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) slot_q[wr_ptr_q] <= dec;
  end

endmodule

/* sv/mbcd_back.sv */
// Back end: per-button sequencer that walks the buttons and emits result beats.
module mbcd_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  mbcd_pkg::cfg_t cfg_i,
  input  mbcd_pkg::op_t  op_i,
  input  logic           op_valid_i,
  output logic           op_pop_o,
  mbcd_res_if.source     res_o
);
  import mbcd_pkg::*;

  seq_e                    state_q, state_d;
  op_t                     cur_q;
  logic [BTN_W-1:0]        cnt_q;
  logic                    sw_q;
  phase_e                  phase_q [NUM_BUTTONS];
  logic [HOLD_W-1:0]       hold_q [NUM_BUTTONS];
  logic [NUM_BUTTONS-1:0]  sr_q;
  logic signed [POS_W-1:0] ax_q [NUM_BUTTONS];
  logic signed [POS_W-1:0] ay_q [NUM_BUTTONS];
  logic                    out_valid_q;
  res_t                    res_q;

  logic              out_free, advance, walk_last;
  logic [BTN_W-1:0]  idx;
  phase_e            ph;
  logic [HOLD_W-1:0] hold;
  logic              active;

  // step actions
  logic              emit, done, sw_we, sw_wd;
  res_t              emit_res;
  logic              ph_we, hold_we, anc_we, sr_we, sr_wd;
  phase_e            ph_wd;
  logic [HOLD_W-1:0] hold_wd;
  logic [BTN_W-1:0]  sr_idx;

  // wheel and move arithmetic
  logic signed [POS_W:0] dx, dy, wd;
  logic [POS_W:0]        adx, ady;
  logic [POS_W-1:0]      mag;
  logic [SUF_W-1:0]      wsuf;
  logic                  beyond;

  assign out_free  = !out_valid_q || res_o.ready;
  assign advance   = (state_q != SEQ_IDLE) && out_free;
  assign walk_last = cnt_q == BTN_W'(NUM_BUTTONS - 1);
  assign idx       = (state_q == SEQ_WALK) ? cnt_q : cur_q.btn;
  assign ph        = phase_q[idx];
  assign hold      = hold_q[idx];
  assign active    = (ph == PH_PENDING) || (ph == PH_CONSUMED);
  assign op_pop_o  = (state_q == SEQ_IDLE) && op_valid_i;

  assign dx     = (POS_W+1)'(cur_q.pos_x) - (POS_W+1)'(ax_q[idx]);
  assign dy     = (POS_W+1)'(cur_q.pos_y) - (POS_W+1)'(ay_q[idx]);
  assign adx    = dx[POS_W] ? (POS_W+1)'(-dx) : (POS_W+1)'(dx);
  assign ady    = dy[POS_W] ? (POS_W+1)'(-dy) : (POS_W+1)'(dy);
  assign beyond = (adx > (POS_W+1)'(cfg_i.drag)) || (ady > (POS_W+1)'(cfg_i.drag));
  assign wd     = (POS_W+1)'(cur_q.wheel);
  assign mag    = POS_W'(wd[POS_W] ? -wd : wd);
  assign wsuf   = wd[POS_W] ? WHEEL_DOWN_SUFFIX : WHEEL_UP_SUFFIX;

  // Action of the current step
  always_comb begin
    emit     = 1'b0;
    emit_res = mk_res(KIND_DECISION, '0, '0, '0);
    done     = 1'b0;
    sw_we    = 1'b0;
    sw_wd    = 1'b0;
    ph_we    = 1'b0;
    ph_wd    = PH_IDLE;
    hold_we  = 1'b0;
    hold_wd  = '0;
    anc_we   = 1'b0;
    sr_we    = 1'b0;
    sr_wd    = 1'b0;
    sr_idx   = cur_q.btn;
    unique case (state_q)
      SEQ_PRE: begin
        if (cur_q.op == OP_DOWN) begin
          if (ph != PH_IDLE) begin
            ph_we   = 1'b1;
            hold_we = 1'b1;
            if (ph == PH_PASS) begin
              emit     = 1'b1;
              emit_res = mk_res(KIND_UP, idx, '0, '0);
            end
          end
          sr_we = 1'b1;
          done  = !cfg_i.enable;
        end else begin
          done  = 1'b1;
          sw_we = 1'b1;
          if (sr_q[idx]) begin
            sr_we = 1'b1;
            sw_wd = 1'b1;
          end else begin
            unique case (ph)
              PH_PENDING: begin
                ph_we   = 1'b1;
                hold_we = 1'b1;
                sw_wd   = 1'b1;
                if (single_mode(cfg_i.modes, idx) == MODE_CLICK) begin
                  emit     = 1'b1;
                  emit_res = mk_res(KIND_CLICK, idx, '0, '0);
                end else if (single_mode(cfg_i.modes, idx) != MODE_DISABLE) begin
                  emit     = 1'b1;
                  emit_res = mk_res(KIND_SINGLE, idx, '0, '0);
                end
              end
              PH_CONSUMED: begin
                ph_we   = 1'b1;
                hold_we = 1'b1;
                sw_wd   = 1'b1;
              end
              PH_PASS: ph_we = 1'b1;
              default: ;
            endcase
          end
        end
      end
      SEQ_WALK: begin
        priority case (cur_q.op)
          OP_DOWN, OP_WHEEL: begin
            if (cur_q.op == OP_DOWN && idx == cur_q.btn) begin
            end else if (active && cfg_i.enable &&
                         chord_mapped(cfg_i.chord_map, idx,
                                      (cur_q.op == OP_DOWN) ? cur_q.btn : wsuf)) begin
              emit     = 1'b1;
              emit_res = (cur_q.op == OP_DOWN) ? mk_res(KIND_CHORD, idx, cur_q.btn, '0)
                                               : mk_res(KIND_CHORD, idx, wsuf, mag);
              ph_we    = 1'b1;
              ph_wd    = PH_CONSUMED;
              hold_we  = 1'b1;
              sr_we    = (cur_q.op == OP_DOWN);
              sr_wd    = 1'b1;
              sw_we    = 1'b1;
              sw_wd    = 1'b1;
              done     = 1'b1;
            end else if (ph == PH_PENDING) begin
              emit     = 1'b1;
              emit_res = mk_res(KIND_DOWN, idx, '0, '0);
              ph_we    = 1'b1;
              ph_wd    = PH_PASS;
              hold_we  = 1'b1;
            end
          end
          OP_MOVE: begin
            if (ph == PH_PENDING && beyond) begin
              emit     = 1'b1;
              emit_res = mk_res(KIND_DOWN, idx, '0, '0);
              ph_we    = 1'b1;
              ph_wd    = PH_PASS;
              hold_we  = 1'b1;
            end
          end
          OP_TICK: begin
            if (ph == PH_PENDING && hold != '0) begin
              hold_we = 1'b1;
              hold_wd = hold - 1'b1;
              if (hold == HOLD_W'(1)) begin
                emit     = 1'b1;
                emit_res = mk_res(KIND_DOWN, idx, '0, '0);
                ph_we    = 1'b1;
                ph_wd    = PH_PASS;
              end
            end
          end
          default: begin
            // flush: release passthrough buttons, optionally deliver held clicks
            ph_we   = 1'b1;
            hold_we = 1'b1;
            sr_we   = 1'b1;
            sr_idx  = idx;
            if (ph == PH_PASS) begin
              emit     = 1'b1;
              emit_res = mk_res(KIND_UP, idx, '0, '0);
            end else if (ph == PH_PENDING && cur_q.op == OP_FLUSH_DLV) begin
              emit     = 1'b1;
              emit_res = mk_res(KIND_CLICK, idx, '0, '0);
            end
          end
        endcase
      end
      SEQ_POST: begin
        done = 1'b1;
        if (is_armed(cfg_i, idx)) begin
          ph_we   = 1'b1;
          ph_wd   = PH_PENDING;
          hold_we = 1'b1;
          hold_wd = cfg_i.holds[int'(idx) * HOLD_W +: HOLD_W];
          anc_we  = 1'b1;
          sw_we   = 1'b1;
          sw_wd   = 1'b1;
        end
      end
      SEQ_DEC: begin
        emit_res         = mk_res(KIND_DECISION, '0, '0, '0);
        emit_res.swallow = sw_q;
        emit_res.last    = 1'b1;
      end
      default: ;
    endcase
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      SEQ_IDLE: begin
        if (op_valid_i) begin
          priority case (op_i.op)
            OP_NOP:        state_d = SEQ_DEC;
            OP_DOWN, OP_UP: state_d = SEQ_PRE;
            OP_WHEEL:      state_d = (op_i.wheel == '0) ? SEQ_DEC : SEQ_WALK;
            default:       state_d = SEQ_WALK;
          endcase
        end
      end
      SEQ_PRE: if (advance) state_d = done ? SEQ_DEC : SEQ_WALK;
      SEQ_WALK: begin
        if (advance) begin
          if (done) state_d = SEQ_DEC;
          else if (walk_last) state_d = (cur_q.op == OP_DOWN) ? SEQ_POST : SEQ_DEC;
        end
      end
      SEQ_POST: if (advance) state_d = SEQ_DEC;
      SEQ_DEC:  if (advance) state_d = SEQ_IDLE;
      default:  state_d = SEQ_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SEQ_IDLE;
      cnt_q       <= '0;
      sw_q        <= 1'b0;
      sr_q        <= '0;
      out_valid_q <= 1'b0;
      for (int b = 0; b < NUM_BUTTONS; b++) begin
        phase_q[b] <= PH_IDLE;
        hold_q[b]  <= '0;
      end
    end else begin
      state_q <= state_d;
      if (op_pop_o) begin
        cnt_q <= '0;
        sw_q  <= 1'b0;
      end else if (advance) begin
        if (state_q == SEQ_WALK) cnt_q <= cnt_q + 1'b1;
        if (sw_we) sw_q <= sw_wd;
        if (ph_we) phase_q[idx] <= ph_wd;
        if (hold_we) hold_q[idx] <= hold_wd;
        if (sr_we) sr_q[sr_idx] <= sr_wd;
      end
      if (advance && (emit || state_q == SEQ_DEC)) out_valid_q <= 1'b1;
      else if (res_o.ready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (op_pop_o) cur_q <= op_i;
    if (advance && anc_we) begin
      ax_q[idx] <= cur_q.pos_x;
      ay_q[idx] <= cur_q.pos_y;
    end
    if (advance && (emit || state_q == SEQ_DEC)) res_q <= emit_res;
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.kind         = res_q.kind;
  assign res_o.which_button = res_q.which;
  assign res_o.suffix       = res_q.suffix;
  assign res_o.amount       = res_q.amount;
  assign res_o.swallow      = res_q.swallow;
  assign res_o.last         = res_q.last;

endmodule

/* sv/mouse_button_chord_detector.sv */
// Top level: configuration registers, front queue and back sequencer.
// Every mouse event beat yields zero or more side beats (injected click, down or
// up, chord action, single action) followed by exactly one decision beat with
// last set, whose swallow bit says whether the original event is suppressed.
// Events enter a two-deep queue, so the source can run ahead of the sequencer.
// The sequencer handles one event at a time, in steps: it takes the event from the
// queue, handles the pressed or released button, walks the buttons one by one
// for commands that look at all buttons (five here), arms a new press, and
// emits the decision. Later steps stall while a result sink with ready low
// still holds an earlier result beat.
// Configuration writes are always accepted; write only while no event is in
// flight. A write to an index beyond the last register is dropped.
module mouse_button_chord_detector (
  input  logic        clk_i,
  input  logic        rst_ni,
  mbcd_evt_if.sink    evt_i,
  mbcd_cfg_if.sink    cfg_i,
  mbcd_res_if.source  res_o
);
  import mbcd_pkg::*;

  cfg_t cfg_q;
  op_t  op;
  logic op_valid, op_pop;

  assign cfg_i.ready = 1'b1;

  // register file; each write takes the low bits of the data beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{enable: 1'b0, drag: DRAG_RESET, chord_map: '0, modes: '0, holds: '0};
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_ENABLE: cfg_q.enable    <= cfg_i.data[0];
        CFG_DRAG:   cfg_q.drag      <= cfg_i.data[DRAG_W-1:0];
        CFG_CHORD:  cfg_q.chord_map <= cfg_i.data[CHORD_W-1:0];
        CFG_MODES:  cfg_q.modes     <= cfg_i.data[MODE_W-1:0];
        CFG_HOLDS:  cfg_q.holds     <= cfg_i.data[HOLDS_W-1:0];
        default: ;
      endcase
    end
  end

  mbcd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .evt_i      (evt_i),
    .op_o       (op),
    .op_valid_o (op_valid),
    .op_pop_i   (op_pop)
  );

  mbcd_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .op_i       (op),
    .op_valid_i (op_valid),
    .op_pop_o   (op_pop),
    .res_o      (res_o)
  );

`ifndef SYNTHESIS
  // the decision beat and only the decision beat closes an event
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> (res_o.last == (res_o.kind == KIND_DECISION)))
    else $error("last flag does not match decision kind");

  // side beats never carry a swallow
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && !res_o.last |-> !res_o.swallow)
    else $error("swallow set on a side beat");

  // the sequencer only takes from a non-empty queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    op_pop |-> op_valid)
    else $error("pop from empty event queue");
`endif

endmodule
